// ----- rtl/srs_pkg.sv -----
// shared types and constants for the shadow return stack checker
// no dependencies; imported by every module of the block
package srs_pkg;

    localparam int ADDR_W          = 64;
    localparam int STATUS_W        = 3;
    localparam int OUT_W           = 9;
    localparam int DEF_STACK_DEPTH = 256;

    localparam logic REQ_PUSH   = 1'b0;
    localparam logic REQ_RETURN = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED    = 3'd0,
        ST_TOP       = 3'd1,
        ST_DEEPER    = 3'd2,
        ST_VIOLATION = 3'd3,
        ST_UNDERFLOW = 3'd4,
        ST_OVERFLOW  = 3'd5
    } srs_status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic        capture;
        logic        track_top;
        logic        write_push;
        logic        pop;
        logic        step;
        logic        load_out;
        srs_status_t result;
    } srs_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_push;
        logic full;
        logic empty;
        logic hit;
        logic at_top;
        logic at_bottom;
        logic out_free;
    } srs_stat_t;

endpackage

// ----- rtl/srs_datapath.sv -----
// datapath: return address memory, depth counter, search pointer, output register
// depends on srs_pkg
module srs_datapath #(
    parameter int STACK_DEPTH = srs_pkg::DEF_STACK_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_type,
    input  logic [srs_pkg::ADDR_W-1:0]    return_address,
    input  srs_pkg::srs_cmd_t             cmd,
    output srs_pkg::srs_stat_t            stat,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [srs_pkg::STATUS_W-1:0]  status,
    output logic [srs_pkg::OUT_W-1:0]     match_position,
    output logic [srs_pkg::OUT_W-1:0]     depth_after
);
    import srs_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] FULL_DEPTH = DW'(STACK_DEPTH);

    logic [ADDR_W-1:0]   mem [STACK_DEPTH];
    logic [ADDR_W-1:0]   rdata_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                req_reg;
    logic [AW-1:0]       ptr_reg;
    logic [AW-1:0]       ptr_next;
    logic [DW-1:0]       depth_reg;
    logic [DW-1:0]       depth_next;
    logic [DW-1:0]       depth_dec;
    logic [AW-1:0]       top_idx;
    logic [AW-1:0]       ptr_dec;
    logic [AW-1:0]       rd_addr;
    logic [DW-1:0]       pos_full;
    logic [DW+OUT_W-1:0] pos_ext;
    logic [DW+OUT_W-1:0] depth_ext;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [OUT_W-1:0]    out_pos_reg;
    logic [OUT_W-1:0]    out_depth_reg;

    assign depth_dec = depth_reg - DW'(1);
    assign top_idx   = depth_dec[AW-1:0];
    assign ptr_dec   = ptr_reg - AW'(1);
    assign pos_full  = DW'(ptr_reg) + DW'(1);
    assign pos_ext   = {{OUT_W{1'b0}}, pos_full};
    assign depth_ext = {{OUT_W{1'b0}}, depth_next};

    // while idle keep the top entry in the read register so a return can compare at once
    always_comb
    begin
        if (cmd.step)
        begin
            rd_addr = ptr_dec;
        end
        else if (cmd.track_top)
        begin
            rd_addr = top_idx;
        end
        else
        begin
            rd_addr = ptr_reg;
        end
    end

    always_comb
    begin
        depth_next = depth_reg;
        if (cmd.write_push)
        begin
            depth_next = depth_reg + DW'(1);
        end
        else if (cmd.pop)
        begin
            depth_next = depth_dec;
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.capture)
        begin
            ptr_next = top_idx;
        end
        else if (cmd.step)
        begin
            ptr_next = ptr_dec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_push)
        begin
            mem[depth_reg[AW-1:0]] <= addr_reg;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= req_type;
            addr_reg <= return_address;
        end
        ptr_reg <= ptr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.result;
            out_depth_reg  <= depth_ext[OUT_W-1:0];
            if (cmd.result inside {ST_TOP, ST_DEEPER})
            begin
                out_pos_reg <= pos_ext[OUT_W-1:0];
            end
            else
            begin
                out_pos_reg <= '0;
            end
        end
    end

    assign stat.is_push   = (req_reg == REQ_PUSH);
    assign stat.full      = (depth_reg == FULL_DEPTH);
    assign stat.empty     = (depth_reg == '0);
    assign stat.hit       = (rdata_reg == addr_reg);
    assign stat.at_top    = (ptr_reg == top_idx);
    assign stat.at_bottom = (ptr_reg == '0);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign match_position = out_pos_reg;
    assign depth_after    = out_depth_reg;

endmodule

// ----- rtl/srs_ctrl.sv -----
// controller: sequences one item at a time through the datapath
// depends on srs_pkg
module srs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  srs_pkg::srs_stat_t stat,
    output srs_pkg::srs_cmd_t  cmd
);
    import srs_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    always_comb
    begin
        cmd           = '0;
        cmd.result    = ST_PUSHED;
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.track_top = 1'b1;
                if (in_valid && in_ready_reg)
                begin
                    cmd.capture   = 1'b1;
                    state_next    = S_EXEC;
                    in_ready_next = 1'b0;
                end
            end
            S_EXEC:
            begin
                if (stat.is_push)
                begin
                    if (stat.out_free)
                    begin
                        cmd.load_out   = 1'b1;
                        cmd.write_push = !stat.full;
                        cmd.result     = stat.full ? ST_OVERFLOW : ST_PUSHED;
                    end
                end
                else if (stat.empty)
                begin
                    cmd.load_out = stat.out_free;
                    cmd.result   = ST_UNDERFLOW;
                end
                else if (stat.hit)
                begin
                    cmd.load_out = stat.out_free;
                    cmd.pop      = stat.out_free;
                    cmd.result   = stat.at_top ? ST_TOP : ST_DEEPER;
                end
                else if (stat.at_bottom)
                begin
                    cmd.load_out = stat.out_free;
                    cmd.result   = ST_VIOLATION;
                end
                else
                begin
                    // walk one entry further down
                    cmd.step = 1'b1;
                end
                if (cmd.load_out)
                begin
                    state_next    = S_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// ----- rtl/shadow_return_stack_checker.sv -----
// shadow return address stack checker, top level
// instantiates srs_ctrl and srs_datapath; depends on srs_pkg
//
// Input channel (in_valid/in_ready) carries req_type and return_address:
// a push stores the address, a return checks it against the stack.
// Output channel (out_valid/out_ready) carries one result per input transfer:
// status, match_position (1 = bottom entry) and depth_after.
// One item is worked on at a time. A push, an overflow, an underflow and a
// return that matches the top entry are decided without a walk. A return
// that misses the top walks the memory one entry a cycle (single read
// port) towards the bottom: a deeper match ends the walk at its position,
// a violation ends it at the bottom entry.
// The result sits in an output register; the next item is taken while it
// waits, and that item finishes once the register is free again. A stalled
// receiver therefore holds the block after at most one extra item.
// Reset empties the stack at once; memory contents are not cleared.
module shadow_return_stack_checker #(
    parameter int STACK_DEPTH = srs_pkg::DEF_STACK_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [srs_pkg::ADDR_W-1:0]    return_address,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [srs_pkg::STATUS_W-1:0]  status,
    output logic [srs_pkg::OUT_W-1:0]     match_position,
    output logic [srs_pkg::OUT_W-1:0]     depth_after
);
    import srs_pkg::*;

    srs_cmd_t  cmd;
    srs_stat_t stat;

    srs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srs_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_type       (req_type),
        .return_address (return_address),
        .cmd            (cmd),
        .stat           (stat),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .status         (status),
        .match_position (match_position),
        .depth_after    (depth_after)
    );

    // one item in flight: no back-to-back input transfers
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    // a top match pops the entry it reports
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_TOP |-> match_position == depth_after + 9'd1)
        else $error("top match position does not follow depth");

    // underflow leaves the stack empty and reports no position
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_UNDERFLOW |-> depth_after == '0 && match_position == '0)
        else $error("underflow result inconsistent");

    // pushes never report a match position
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_PUSHED || status == ST_OVERFLOW) |-> match_position == '0)
        else $error("push result carries a position");

endmodule

// ----- sim/tb_shadow_return_stack_checker.sv -----
// self-checking testbench for the shadow return stack checker
// keeps its own copy of the return stack to predict every result; depends on srs_pkg and the rtl
`timescale 1ns / 1ps

module tb_shadow_return_stack_checker;

    import srs_pkg::*;

    localparam int  TB_DEPTH    = DEF_STACK_DEPTH;
    localparam int  HOLD_CYCLES = 400;
    localparam int  DRAIN_TAIL  = 300;   // longest walk is about one cycle per entry
    localparam int  MAX_REPORTS = 60;
    localparam time TIMEOUT_NS  = 12_000_000;

    typedef struct {
        srs_status_t        status;
        logic [OUT_W-1:0]   pos;
        logic [OUT_W-1:0]   depth;
    } stack_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               req_type = REQ_PUSH;
    logic [ADDR_W-1:0]  return_address = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [OUT_W-1:0]   match_position;
    logic [OUT_W-1:0]   depth_after;

    // predictor state: mirror of the return stack
    logic [ADDR_W-1:0]  shadow_copy [TB_DEPTH];
    int                 copy_depth = 0;

    stack_result_t      pending_results[$];
    int                 error_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    logic               hold_req = 1'b0;
    int                 hold_left = 0;

    shadow_return_stack_checker #(
        .STACK_DEPTH(TB_DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .return_address (return_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .match_position (match_position),
        .depth_after    (depth_after)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    // works out the result of one item and updates the mirrored stack
    function automatic stack_result_t predict_stack(input logic kind,
                                                    input logic [ADDR_W-1:0] addr);
        stack_result_t r;
        int p;
        r.pos = '0;
        if (kind == REQ_PUSH)
        begin
            if (copy_depth >= TB_DEPTH)
                r.status = ST_OVERFLOW;
            else
            begin
                shadow_copy[copy_depth] = addr;
                copy_depth++;
                r.status = ST_PUSHED;
            end
        end
        else if (copy_depth == 0)
            r.status = ST_UNDERFLOW;
        else if (shadow_copy[copy_depth-1] == addr)
        begin
            r.status = ST_TOP;
            r.pos = OUT_W'(copy_depth);
            copy_depth--;
        end
        else
        begin
            r.status = ST_VIOLATION;
            // highest match below the top wins
            for (p = copy_depth - 1; p > 0; p--)
            begin
                if (r.status == ST_VIOLATION && shadow_copy[p-1] == addr)
                begin
                    r.status = ST_DEEPER;
                    r.pos = OUT_W'(p);
                end
            end
            // only the top entry goes, whatever depth matched
            if (r.status == ST_DEEPER)
                copy_depth--;
        end
        r.depth = OUT_W'(copy_depth);
        return r;
    endfunction

    // entered and left at a rising edge; returns at the edge of the transfer
    task automatic send_item(input logic kind, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= kind;
        return_address <= addr;
        pending_results.push_back(predict_stack(kind, addr));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained(input int tail);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic report_mismatch(input string field, input int exp_v, input int act_v);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
    endtask

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_left != 0)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
    end

    // result checker
    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result transfer, status %0d", $time, status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status != want.status)
                    report_mismatch("status", want.status, status);
                if (match_position != want.pos)
                    report_mismatch("match_position", want.pos, match_position);
                if (depth_after != want.depth)
                    report_mismatch("depth_after", want.depth, depth_after);
            end
        end
    end

    task automatic test_directed();
        logic [ADDR_W-1:0] a, b, c, x;
        a = rand_addr();
        b = rand_addr();
        c = rand_addr();
        x = rand_addr();
        send_item(REQ_RETURN, rand_addr());        // return on empty stack
        send_item(REQ_PUSH, '0);
        send_item(REQ_PUSH, '1);
        send_item(REQ_RETURN, '1);
        send_item(REQ_RETURN, '0);
        send_item(REQ_RETURN, '0);                 // empty again
        send_item(REQ_PUSH, a);
        send_item(REQ_PUSH, b);
        send_item(REQ_PUSH, c);
        send_item(REQ_RETURN, a);                  // bottom match, pops the top only
        send_item(REQ_RETURN, ~b);                 // no match anywhere
        send_item(REQ_RETURN, b);
        send_item(REQ_RETURN, a);
        send_item(REQ_PUSH, x);
        send_item(REQ_PUSH, x);
        send_item(REQ_PUSH, c);
        send_item(REQ_RETURN, x);                  // duplicate: upper copy is found
        send_item(REQ_RETURN, x);
        send_item(REQ_RETURN, x);
        send_item(REQ_PUSH, 64'h5555_5555_5555_5555);
        send_item(REQ_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(REQ_RETURN, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(REQ_RETURN, 64'h5555_5555_5555_5555);
        wait_drained(4);
    endtask

    task automatic test_fill_overflow();
        int i;
        for (i = 0; i < TB_DEPTH; i++)
            send_item(REQ_PUSH, rand_addr());
        send_item(REQ_PUSH, rand_addr());          // full: rejected
        send_item(REQ_PUSH, '1);
        send_item(REQ_RETURN, shadow_copy[copy_depth-1]);
        send_item(REQ_PUSH, rand_addr());
        send_item(REQ_RETURN, rand_addr());        // walks the whole stack
        send_item(REQ_RETURN, shadow_copy[0]);
        send_item(REQ_RETURN, shadow_copy[copy_depth-1]);
        wait_drained(4);
    endtask

    // receiver stalls for a long stretch while the sender keeps offering
    task automatic test_receiver_hold();
        int i;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (i = 0; i < 8; i++)
        begin
            if (i % 3 == 2 && copy_depth != 0)
                send_item(REQ_RETURN, shadow_copy[copy_depth-1]);
            else
                send_item(REQ_PUSH, rand_addr());
        end
        wait_drained(4);
    endtask

    task automatic test_random(input int n_items, input int s_pct, input int r_pct);
        int i;
        int push_pct;
        int phase_left;
        int sel;
        logic kind;
        logic [ADDR_W-1:0] addr;
        send_idle_pct = s_pct;
        recv_idle_pct <= r_pct;
        push_pct = 70;
        phase_left = 0;
        for (i = 0; i < n_items; i++)
        begin
            // alternate push-heavy and return-heavy runs so depth sweeps the range
            if (phase_left == 0)
            begin
                push_pct = (push_pct == 70) ? 25 : 70;
                phase_left = $urandom_range(40, 200);
            end
            phase_left--;
            sel = $urandom_range(99);
            if ($urandom_range(99) < 8)
            begin
                kind = 1'($urandom_range(1));
                addr = rand_addr();
            end
            else if ($urandom_range(99) < push_pct)
            begin
                kind = REQ_PUSH;
                if (sel < 80 || copy_depth == 0)
                    addr = rand_addr();
                else if (sel < 92)
                    addr = shadow_copy[$urandom_range(copy_depth - 1)];
                else
                    addr = $urandom_range(1) ? '1 : '0;
            end
            else
            begin
                kind = REQ_RETURN;
                if (copy_depth == 0 || sel < 70)
                    addr = (copy_depth == 0) ? rand_addr() : shadow_copy[copy_depth-1];
                else if (sel < 88 && copy_depth >= 2)
                    addr = shadow_copy[$urandom_range(copy_depth - 2)];
                else
                    addr = rand_addr();
            end
            send_item(kind, addr);
        end
        wait_drained(4);
    endtask

    initial
    begin
        send_idle_pct = 31;
        recv_idle_pct <= 47;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_overflow();
        test_receiver_hold();
        test_random(500, 47, 31);
        test_random(500, 0, 0);
        wait_drained(DRAIN_TAIL);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
